### rtl/indexed_list_engine_top_macros.svh
// assertion macros used by the checker file
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list engine check failed");

// next-cycle implication, disabled during reset
`define ILE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list engine check failed");

`endif

### rtl/ile_pkg.sv
`default_nettype none
package ile_pkg;

  // list geometry
  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int TOT_W      = 5;
  // compare width wide enough for both position and count
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ile_status_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              load_tail;
    logic              shift_up;
    logic              shift_down;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  count;
    logic [DATA_W-1:0] data;
  } ile_ctrl_t;

endpackage
`default_nettype wire

### rtl/ile_cell.sv
`default_nettype none
module ile_cell (
  input  wire logic                     clk,
  input  wire ile_pkg::ile_ctrl_t       ctrl,
  input  wire logic [ile_pkg::CMP_W-1:0]  idx,
  input  wire logic [ile_pkg::DATA_W-1:0] prev_val,
  input  wire logic [ile_pkg::DATA_W-1:0] next_val,
  output logic      [ile_pkg::DATA_W-1:0] val,
  output logic      [ile_pkg::DATA_W-1:0] rd_val
);
  import ile_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  // pick the new content: hold, load, or take a neighbor's word
  always_comb begin
    val_nxt = val_r;
    if (ctrl.load_tail && (idx == ctrl.count)) begin
      val_nxt = ctrl.data;
    end else if (ctrl.shift_up) begin
      if (idx == ctrl.pos) begin
        val_nxt = ctrl.data;
      end else if (idx > ctrl.pos) begin
        val_nxt = prev_val;
      end
    end else if (ctrl.shift_down && (idx >= ctrl.pos)) begin
      val_nxt = next_val;
    end
  end

  // cell storage, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  // masked read, or-combined at the top
  assign rd_val = (idx == ctrl.pos) ? val_r : '0;

endmodule
`default_nettype wire

### rtl/indexed_list_engine_top.sv
`default_nettype none
// Ordered list of up to LIST_DEPTH signed 32-bit words held in a row of cells,
// each cell shifting to or from its neighbor in the same cycle. An operation
// is taken whenever start is high; busy stays low, so one operation is taken
// every clock. Its result appears on the out_ ports in the next cycle for exactly
// one cycle, marked by out_valid; the receiver cannot stall and must capture it
// then. The cell row shifts in parallel and the result passes through one output
// register. After reset the list is empty; no clearing pass is needed.
module indexed_list_engine_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ile_pkg::OP_W-1:0]        in_operation,
  input  wire logic [ile_pkg::POS_W-1:0]       in_position,
  input  wire logic signed [ile_pkg::DATA_W-1:0] in_data_value,
  output logic                                 out_valid,
  output logic signed [ile_pkg::DATA_W-1:0]    out_read_value,
  output logic      [1:0]                      out_status,
  output logic      [ile_pkg::TOT_W-1:0]       out_entry_total
);
  import ile_pkg::*;

  logic                  accept;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [DATA_W-1:0]     rd_r;
  logic [DATA_W-1:0]     rd_nxt;
  ile_status_t           status_r;
  ile_status_t           status_nxt;
  logic [TOT_W-1:0]      total_r;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CMP_W-1:0]      cnt_nxt_x;
  logic                  full;
  logic [DATA_W-1:0]     rd_or;
  ile_ctrl_t             ctrl;
  logic [DATA_W-1:0]     cell_val [LIST_DEPTH];
  logic [DATA_W-1:0]     cell_rd  [LIST_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_x = CMP_W'(in_position);
  assign cnt_x = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(LIST_DEPTH));

  // or-combine the masked cell reads
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // decode the operation into cell control, status and new count
  always_comb begin
    ctrl            = '0;
    ctrl.pos        = pos_x;
    ctrl.count      = cnt_x;
    ctrl.data       = in_data_value;
    count_nxt       = count_r;
    status_nxt      = ST_OK;
    rd_nxt          = '0;
    case (in_operation)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.load_tail = accept;
          count_nxt      = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.shift_up = accept;
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.shift_down = accept;
          count_nxt       = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = rd_or;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign cnt_nxt_x = CMP_W'(count_nxt);

  // row of cells
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_val[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign next_w = cell_val[g];
    end else begin : g_mid_next
      assign next_w = cell_val[g+1];
    end
    ile_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (CMP_W'(g)),
      .prev_val (prev_w),
      .next_val (next_w),
      .val      (cell_val[g]),
      .rd_val   (cell_rd[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r     <= rd_nxt;
      status_r <= status_nxt;
      total_r  <= cnt_nxt_x[TOT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_r;
  assign out_status      = status_r;
  assign out_entry_total = total_r;

endmodule
`default_nettype wire

### rtl/ile_checker.sv
`default_nettype none
`include "indexed_list_engine_top_macros.svh"
module ile_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [ile_pkg::DATA_W-1:0] out_read_value,
  input wire logic [1:0]                out_status,
  input wire logic [ile_pkg::TOT_W-1:0] out_entry_total
);
  import ile_pkg::*;

  // every taken word yields a result in the next cycle
  `ILE_ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  // no result without a taken word
  `ILE_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_valid)
  // a rejected operation returns a zero read value
  `ILE_ASSERT_NOW(a_reject_zero, out_valid && (out_status != ST_OK), out_read_value == '0)
  // a rejected operation leaves the count as the previous result showed it
  `ILE_ASSERT_NOW(a_reject_keeps_count,
    out_valid && $past(out_valid) && (out_status != ST_OK),
    out_entry_total == $past(out_entry_total))

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entry_total (out_entry_total)
);
`default_nettype wire

### bench/indexed_list_engine_top_tb.sv
`default_nettype none
module indexed_list_engine_top_tb;
  import ile_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYC   = 12;
  localparam int RANDOM_WORDS = 1850;
  localparam int QUIET_TAIL  = 200;
  localparam int CYCLE_LIMIT = 200000;

  // one expected result word
  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    ile_status_t              status;
    logic [TOT_W-1:0]         entry_total;
  } list_reply_t;

  // operation mix of a stretch of random words
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  // shadow copy of the list plus the replies still owed
  class list_mirror;
    logic signed [DATA_W-1:0] cells [LIST_DEPTH];
    int unsigned              count;
    list_reply_t              replies [$];
    int unsigned              errors;

    function new();
      count = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction

    // apply one accepted word and queue the reply it must produce
    function void take_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] val);
      list_reply_t r;
      int unsigned i;
      r.read_value = '0;
      r.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        OP_INSERT: begin
          // position is checked before fullness
          if (pos > count) begin
            r.status = ST_RANGE;
          end else if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
          end
        end
        OP_REMOVE: begin
          if (pos >= count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        OP_READ: begin
          if (pos >= count) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = cells[pos];
          end
        end
      endcase
      r.entry_total = count[TOT_W-1:0];
      replies.push_back(r);
    endfunction

    // compare a result word with the oldest reply owed
    function void check_word(logic signed [DATA_W-1:0] rd, logic [1:0] st,
                             logic [TOT_W-1:0] tot);
      list_reply_t r;
      if (replies.size() == 0) begin
        errors++;
        $error("result word with no operation pending");
        return;
      end
      r = replies.pop_front();
      if (rd !== r.read_value) begin
        errors++;
        $error("read_value: expected %0d, got %0d", r.read_value, rd);
      end
      if (st !== r.status) begin
        errors++;
        $error("status: expected %0d, got %0d", r.status, st);
      end
      if (tot !== r.entry_total) begin
        errors++;
        $error("entry_total: expected %0d, got %0d", r.entry_total, tot);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [OP_W-1:0]            in_operation = OP_APPEND;
  logic [POS_W-1:0]           in_position = '0;
  logic signed [DATA_W-1:0]   in_data_value = '0;
  logic                       out_valid;
  logic signed [DATA_W-1:0]   out_read_value;
  logic [1:0]                 out_status;
  logic [TOT_W-1:0]           out_entry_total;

  list_mirror  mirror;
  int unsigned cycles = 0;

  indexed_list_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_total (out_entry_total)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // sample both sides at the rising edge, and watch for a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid) mirror.check_word(out_read_value, out_status, out_entry_total);
      if (start && !busy) mirror.take_word(in_operation, in_position, in_data_value);
    end
  end

  // present one word from a falling edge until it is taken
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    start         <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_data_value <= val;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // keep start low between words
  task automatic hold_off(int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // corner values a third of the draws
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 35) return OP_APPEND;
        else if (r < 70) return OP_INSERT;
        else if (r < 80) return OP_REMOVE;
        else return OP_READ;
      end
      MIX_SHRINK: begin
        if (r < 10) return OP_APPEND;
        else if (r < 25) return OP_INSERT;
        else if (r < 75) return OP_REMOVE;
        else return OP_READ;
      end
      default: return r[1:0];
    endcase
  endfunction

  // mostly legal positions, some on the edge, some anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] op,
                                                     int unsigned cnt);
    int unsigned r;
    int unsigned p;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      if (op == OP_INSERT) p = $urandom_range(0, cnt);
      else if (cnt > 0) p = $urandom_range(0, cnt - 1);
      else p = 0;
    end else if (r == 8) begin
      p = (op == OP_INSERT) ? cnt + 1 : cnt;
    end else begin
      p = $urandom_range(0, 31);
    end
    if (p > 31) p = 31;
    return p[POS_W-1:0];
  endfunction

  // stimulus
  initial begin
    op_mix_t     mix;
    int unsigned stretch;
    int unsigned idle_stretch;
    bit          idle_on;
    logic [OP_W-1:0] op;

    mirror = new();
    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every access on an empty list is out of range
    send_word(OP_READ, 5'd0, 32'h1234_5678);
    send_word(OP_REMOVE, 5'd0, 0);
    send_word(OP_INSERT, 5'd1, 32'h0bad_0bad);
    // fill to the top with corner values, then push past it
    for (int i = 0; i < LIST_DEPTH; i++) begin
      case (i % 6)
        0: send_word(OP_APPEND, 5'h1f, 32'h7fff_ffff);
        1: send_word(OP_APPEND, 5'h00, 32'h8000_0000);
        2: send_word(OP_APPEND, 5'h0a, 32'hffff_ffff);
        3: send_word(OP_APPEND, 5'h15, 32'h0000_0000);
        4: send_word(OP_APPEND, 5'h00, 32'h5555_5555);
        default: send_word(OP_APPEND, 5'h00, 32'haaaa_aaaa);
      endcase
    end
    send_word(OP_APPEND, 5'd0, 32'h0000_0001);
    // full list at a legal position, then a position past the end
    send_word(OP_INSERT, POS_W'(LIST_DEPTH), 32'h0000_0002);
    send_word(OP_INSERT, POS_W'(LIST_DEPTH + 1), 32'h0000_0003);
    send_word(OP_READ, 5'd1, 0);
    send_word(OP_READ, POS_W'(LIST_DEPTH), 0);
    // remove the tail and the head, then insert at the head
    send_word(OP_REMOVE, POS_W'(LIST_DEPTH - 1), 0);
    send_word(OP_REMOVE, 5'd0, 0);
    send_word(OP_INSERT, 5'd0, 32'h8000_0001);

    // random words in stretches of one operation mix
    mix = MIX_GROW;
    stretch = 0;
    idle_stretch = 0;
    idle_on = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: mix = MIX_GROW;
          1: mix = MIX_SHRINK;
          default: mix = MIX_EVEN;
        endcase
      end
      stretch--;
      if (idle_stretch == 0) begin
        idle_stretch = $urandom_range(50, 150);
        idle_on = ($urandom_range(0, 2) != 0);
      end
      idle_stretch--;

      // let everything drain once mid-run
      if (n == RANDOM_WORDS / 2) begin
        start <= 1'b0;
        do @(negedge clk); while (mirror.pending() != 0);
      end else if (idle_on && n < RANDOM_WORDS - QUIET_TAIL &&
                   $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 6));
      end

      op = pick_op(mix);
      send_word(op, pick_position(op, mirror.count), pick_value());
    end
    start <= 1'b0;

    // wait out the last result words
    while (mirror.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mirror.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_top.sv
rtl/ile_checker.sv
bench/indexed_list_engine_top_tb.sv
